// File: sv/huffman_bit_packer_defines.svh
// Assertion macros used by the checker of the Huffman bit packer.
`ifndef HUFFMAN_BIT_PACKER_DEFINES_SVH
`define HUFFMAN_BIT_PACKER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define HBP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define HBP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Implication with no reset qualifier, for checks around reset itself.
`define HBP_ASSERT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: sv/hbp_pkg.sv
// Shared constants, command codes and types of the Huffman bit packer.
`default_nettype none
package hbp_pkg;

  localparam int SYMBOL_COUNT = 256;
  localparam int MAX_CODE_LEN = 32;
  localparam int SYM_W        = 8;
  localparam int CODE_W       = 32;
  localparam int LEN_W        = 6;
  localparam int FILL_W       = 3;
  localparam int ADDR_W       = $clog2(SYMBOL_COUNT);
  localparam int ENTRY_W      = CODE_W + LEN_W;
  localparam int BYTES_MAX    = (CODE_W + 7) / 8;
  localparam int ACC_W        = BYTES_MAX * 8 + 8;
  localparam int NB_W         = $clog2(BYTES_MAX + 1);
  localparam int SH_W         = $clog2(ACC_W + 1);

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_ENCODE = 2'd1,
    CMD_FLUSH  = 2'd2
  } cmd_t;

  typedef struct packed {
    logic [BYTES_MAX*8-1:0] bytes;
    logic [NB_W-1:0]        nbytes;
    logic [7:0]             pend;
    logic [FILL_W-1:0]      fill;
  } merge_res_t;

endpackage
`default_nettype wire

// File: sv/huffman_bit_packer.sv
// Top level of the table-driven MSB-first Huffman bit packer.
//
//   Port group  Direction  Beat contents
//   in_*        input      cmd, symbol, code_bits, code_len
//   out_*       output     out_byte, out_last_of_run
//
// An input beat is taken every cycle while the result side keeps up; out_valid rises once
// an encode or flush beat that yields bytes has passed the registered table read and its
// bytes have been loaded into the byte buffer.
// An encode or flush yields up to four bytes, which the result channel offers one at a time;
// the next result is held in the lookup stage until the last of them is being taken.
// The code table sits in a RAM with a registered read; per-entry valid bits cleared by
// reset mark every symbol absent at once, so no clearing pass is needed.
// Reset is synchronous; stalls on the result side hold the byte buffer and back up into
// in_stall only when a new result cannot yet be buffered.
`default_nettype none
module huffman_bit_packer (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [1:0]                 in_cmd,
  input  wire logic [hbp_pkg::SYM_W-1:0]  in_symbol,
  input  wire logic [hbp_pkg::CODE_W-1:0] in_code_bits,
  input  wire logic [hbp_pkg::LEN_W-1:0]  in_code_len,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [7:0]                      out_byte,
  output logic                            out_last_of_run
);

  logic                              accept;
  logic                              in_range;
  logic [hbp_pkg::ADDR_W-1:0]        addr;
  logic [hbp_pkg::LEN_W-1:0]         len_sat;
  logic [hbp_pkg::CODE_W-1:0]        code_mask;
  logic                              tbl_we;
  logic [hbp_pkg::ENTRY_W-1:0]       tbl_wdata;
  logic [hbp_pkg::ENTRY_W-1:0]       tbl_rdata;
  logic [hbp_pkg::SYMBOL_COUNT-1:0]  vld_r;

  logic                              s1_v_r;
  logic [1:0]                        s1_cmd_r;
  logic                              s1_hit_r;
  logic                              s1_go;
  hbp_pkg::merge_res_t               mres;

  logic [7:0]                        pend_r;
  logic [hbp_pkg::FILL_W-1:0]        fill_r;
  logic [hbp_pkg::BYTES_MAX*8-1:0]   sh_r;
  logic [hbp_pkg::BYTES_MAX*8-1:0]   sh_nxt;
  logic [hbp_pkg::NB_W-1:0]          cnt_r;
  logic [hbp_pkg::NB_W-1:0]          cnt_nxt;
  logic                              buf_free;
  logic                              out_take;

  assign out_valid       = (cnt_r != '0);
  assign out_byte        = sh_r[hbp_pkg::BYTES_MAX*8-1 -: 8];
  assign out_last_of_run = (cnt_r == hbp_pkg::NB_W'(1));
  assign out_take        = out_valid && !out_stall;

  assign buf_free = (cnt_r == '0) || ((cnt_r == hbp_pkg::NB_W'(1)) && !out_stall);
  assign s1_go    = !s1_v_r || (mres.nbytes == '0) || buf_free;
  assign in_stall = s1_v_r && !s1_go;
  assign accept   = in_valid && !in_stall;

  assign in_range  = ({24'b0, in_symbol} < 32'(hbp_pkg::SYMBOL_COUNT));
  assign addr      = hbp_pkg::ADDR_W'(in_symbol);
  assign len_sat   = (in_code_len > hbp_pkg::LEN_W'(hbp_pkg::MAX_CODE_LEN)) ?
                     hbp_pkg::LEN_W'(hbp_pkg::MAX_CODE_LEN) : in_code_len;
  assign code_mask = (len_sat >= hbp_pkg::LEN_W'(hbp_pkg::CODE_W)) ? '1 :
                     ((hbp_pkg::CODE_W'(1) << len_sat) - hbp_pkg::CODE_W'(1));
  assign tbl_we    = accept && (in_cmd == hbp_pkg::CMD_LOAD) && in_range;
  assign tbl_wdata = {len_sat, in_code_bits & code_mask};

  hbp_ram #(
    .WIDTH (hbp_pkg::ENTRY_W),
    .DEPTH (hbp_pkg::SYMBOL_COUNT)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (addr),
    .wdata (tbl_wdata),
    .re    (accept),
    .raddr (addr),
    .rdata (tbl_rdata)
  );

  hbp_merge u_merge (
    .cmd   (s1_cmd_r),
    .hit   (s1_hit_r),
    .entry (tbl_rdata),
    .pend  (pend_r),
    .fill  (fill_r),
    .res   (mres)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (tbl_we) begin
      vld_r[addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_go) begin
      s1_v_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd_r <= in_cmd;
      s1_hit_r <= in_range && vld_r[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      fill_r <= '0;
    end else if (s1_v_r && s1_go) begin
      pend_r <= mres.pend;
      fill_r <= mres.fill;
    end
  end

  always_comb begin
    sh_nxt  = sh_r;
    cnt_nxt = cnt_r;
    if (s1_v_r && s1_go && (mres.nbytes != '0)) begin
      sh_nxt  = mres.bytes;
      cnt_nxt = mres.nbytes;
    end else if (out_take) begin
      sh_nxt  = sh_r << 8;
      cnt_nxt = cnt_r - hbp_pkg::NB_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    sh_r <= sh_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// File: sv/hbp_ram.sv
// Generic single-port-write RAM with a registered read port.
`default_nettype none
module hbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule
`default_nettype wire

// File: sv/hbp_merge.sv
// Merges a looked-up code word into the pending byte and splits out full bytes; a flush emits any partial byte.
`default_nettype none
module hbp_merge (
  input  wire logic [1:0]                  cmd,
  input  wire logic                        hit,
  input  wire logic [hbp_pkg::ENTRY_W-1:0] entry,
  input  wire logic [7:0]                  pend,
  input  wire logic [hbp_pkg::FILL_W-1:0]  fill,
  output hbp_pkg::merge_res_t              res
);

  logic [hbp_pkg::CODE_W-1:0] code;
  logic [hbp_pkg::LEN_W-1:0]  len;
  logic [hbp_pkg::SH_W-1:0]   total;
  logic [hbp_pkg::SH_W-1:0]   shamt;
  logic [hbp_pkg::ACC_W-1:0]  acc;
  logic [hbp_pkg::ACC_W-1:0]  rest;

  always_comb begin
    code  = hit ? entry[hbp_pkg::CODE_W-1:0] : '0;
    len   = hit ? entry[hbp_pkg::ENTRY_W-1 -: hbp_pkg::LEN_W] : '0;
    total = hbp_pkg::SH_W'(fill) + hbp_pkg::SH_W'(len);
    shamt = hbp_pkg::SH_W'(hbp_pkg::ACC_W) - total;
    acc   = {pend, {(hbp_pkg::ACC_W-8){1'b0}}} | (hbp_pkg::ACC_W'(code) << shamt);
    rest  = acc << {total[hbp_pkg::SH_W-1:3], 3'b000};

    res.bytes  = '0;
    res.nbytes = '0;
    res.pend   = pend;
    res.fill   = fill;
    case (cmd)
      hbp_pkg::CMD_ENCODE: begin
        res.bytes  = acc[hbp_pkg::ACC_W-1 -: hbp_pkg::BYTES_MAX*8];
        res.nbytes = hbp_pkg::NB_W'(total >> 3);
        res.pend   = rest[hbp_pkg::ACC_W-1 -: 8];
        res.fill   = hbp_pkg::FILL_W'(total);
      end
      hbp_pkg::CMD_FLUSH: begin
        res.bytes  = {pend, {(hbp_pkg::BYTES_MAX*8-8){1'b0}}};
        res.nbytes = (fill != '0) ? hbp_pkg::NB_W'(1) : '0;
        res.pend   = '0;
        res.fill   = '0;
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// File: sv/hbp_checker.sv
// Port-level checks of the Huffman bit packer and their binding to the top level.
`default_nettype none
`include "huffman_bit_packer_defines.svh"
module hbp_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_stall,
  input wire logic [1:0]                 in_cmd,
  input wire logic [hbp_pkg::SYM_W-1:0]  in_symbol,
  input wire logic [hbp_pkg::CODE_W-1:0] in_code_bits,
  input wire logic [hbp_pkg::LEN_W-1:0]  in_code_len,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire logic [7:0]                 out_byte,
  input wire logic                       out_last_of_run
);

  `HBP_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_byte) && $stable(out_last_of_run),
    "Stalled result beat changed.")
  `HBP_ASSERT_NEXT(a_run_continues, out_valid && !out_stall && !out_last_of_run,
    out_valid, "A byte run broke off before its last beat.")
  `HBP_ASSERT_NOW(a_stall_needs_out, in_stall, out_valid,
    "Input stalled with nothing to deliver.")
  `HBP_ASSERT_NEXT(a_in_hold, in_valid && in_stall,
    in_valid && $stable(in_cmd) && $stable(in_symbol) && $stable(in_code_bits)
    && $stable(in_code_len), "Stalled input beat changed.")
  `HBP_ASSERT_ALWAYS(a_reset_empty, rst_n && $past(!rst_n), !out_valid,
    "Result beat offered right after reset.")

endmodule

bind huffman_bit_packer hbp_checker u_hbp_checker (.*);
`default_nettype wire
